// ===== rtl/core/lsst_pkg.sv =====
// ----------------------------------------------------------------------------
// lsst_pkg
// Shared types, text patterns and event codes for the link status string
// tracker.
// ----------------------------------------------------------------------------
package lsst_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] pos_t;
  typedef logic [1:0] event_t;

  typedef enum logic [2:0] {
    MODE_CONNECT = 3'b001,
    MODE_CRLF    = 3'b010,
    MODE_DISC    = 3'b100
  } mode_t;

  localparam event_t EV_NONE         = 2'd0;
  localparam event_t EV_CONNECTED    = 2'd1;
  localparam event_t EV_DISCONNECTED = 2'd2;

  localparam pos_t LEN_CONNECT = 4'd7;
  localparam pos_t LEN_CRLF    = 4'd2;
  localparam pos_t LEN_DISC    = 4'd10;

  // texts left aligned in 16 byte slots, first character in the top byte
  localparam logic [127:0] TXT_CONNECT = {"CONNECT", 72'h0};
  localparam logic [127:0] TXT_CRLF    = {8'h0D, 8'h0A, 112'h0};
  localparam logic [127:0] TXT_DISC    = {"DISCONNECT", 48'h0};

  typedef struct packed {
    event_t link_event;
    logic   pass_valid;
    byte_t  pass_byte;
  } result_t;

  function automatic byte_t text_char(logic [127:0] txt, pos_t pos);
    logic [6:0] msb;
    msb = 7'd127 - {pos, 3'b000};
    return txt[msb -: 8];
  endfunction

endpackage

// ===== rtl/core/lsst_match.sv =====
// ----------------------------------------------------------------------------
// lsst_match
// Mode and match position tracking. Compares one byte per advance against
// the expected character of the current text and builds the result beat.
// ----------------------------------------------------------------------------
module lsst_match (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv_i,
  input  lsst_pkg::byte_t      byte_i,
  output lsst_pkg::result_t    res_o
);

  lsst_pkg::mode_t  mode_r;
  lsst_pkg::pos_t   pos_r;

  lsst_pkg::mode_t  mode_dec;
  lsst_pkg::mode_t  mode_after;
  logic [127:0]     txt;
  lsst_pkg::pos_t   len;
  lsst_pkg::pos_t   pos_inc;
  lsst_pkg::event_t done_event;
  logic             hit;
  logic             done;
  logic             pass;

  always_comb begin
    unique case (mode_r)
      lsst_pkg::MODE_CRLF: begin
        mode_dec   = lsst_pkg::MODE_CRLF;
        txt        = lsst_pkg::TXT_CRLF;
        len        = lsst_pkg::LEN_CRLF;
        mode_after = lsst_pkg::MODE_DISC;
        done_event = lsst_pkg::EV_CONNECTED;
      end
      lsst_pkg::MODE_DISC: begin
        mode_dec   = lsst_pkg::MODE_DISC;
        txt        = lsst_pkg::TXT_DISC;
        len        = lsst_pkg::LEN_DISC;
        mode_after = lsst_pkg::MODE_CONNECT;
        done_event = lsst_pkg::EV_DISCONNECTED;
      end
      default: begin
        mode_dec   = lsst_pkg::MODE_CONNECT;
        txt        = lsst_pkg::TXT_CONNECT;
        len        = lsst_pkg::LEN_CONNECT;
        mode_after = lsst_pkg::MODE_CRLF;
        done_event = lsst_pkg::EV_NONE;
      end
    endcase
  end

  assign pos_inc = pos_r + 4'd1;
  assign hit     = (pos_r < len) && (byte_i == lsst_pkg::text_char(txt, pos_r));
  assign done    = hit && (pos_inc == len);
  assign pass    = (mode_dec == lsst_pkg::MODE_DISC);

  assign res_o = {(done ? done_event : lsst_pkg::EV_NONE), pass,
                  (pass ? byte_i : 8'h00)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lsst_pkg::MODE_CONNECT;
      pos_r  <= 4'd0;
    end else if (adv_i) begin
      if (!hit) begin
        pos_r  <= 4'd0;
        mode_r <= mode_dec;
      end else if (done) begin
        pos_r  <= 4'd0;
        mode_r <= mode_after;
      end else begin
        pos_r  <= pos_inc;
        mode_r <= mode_dec;
      end
    end
  end

endmodule

// ===== rtl/core/link_status_string_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// link_status_string_tracker_unit
// Watches a receive byte stream for CONNECT, CR LF and DISCONNECT and
// reports link events, forwarding bytes seen while the link is up.
//
// Input channel: one beat carries one received byte (in_rx_byte).
// Result channel: one beat per input beat, in order, carrying link_event
// (none, connected, disconnected), pass_valid and pass_byte.
// Path: the byte lands in the input register when it is accepted, and the
// result register loads from it once the result side can take a beat.
// Throughput: one beat per cycle while out_stall is low; the combinational
// compare and position update between the two registers set this rate.
// Receiver stall: the result register holds its beat; the input register
// keeps accepting until it is full, then in_stall rises in the same cycle
// as the result side stays blocked.
// Reset: both registers empty, mode waits for CONNECT, match position zero.
// ----------------------------------------------------------------------------
module link_status_string_tracker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_link_event,
  output logic       out_pass_valid,
  output logic [7:0] out_pass_byte
);

  logic              in_vld_r;
  lsst_pkg::byte_t   in_byte_r;
  logic              out_vld_r;
  lsst_pkg::result_t out_res_r;

  lsst_pkg::result_t res;
  logic              out_load;
  logic              s1_fire;
  logic              accept;

  assign out_load = !out_vld_r || !out_stall;
  assign s1_fire  = in_vld_r && out_load;
  assign in_stall = in_vld_r && !out_load;
  assign accept   = in_valid && !in_stall;

  lsst_match u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (s1_fire),
    .byte_i (in_byte_r),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (s1_fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_link_event = out_res_r.link_event;
  assign out_pass_valid = out_res_r.pass_valid;
  assign out_pass_byte  = out_res_r.pass_byte;

endmodule

// ===== rtl/core/lsst_check.sv =====
// ----------------------------------------------------------------------------
// lsst_check
// Port-level checks for the link status string tracker, bound to the top.
// ----------------------------------------------------------------------------
module lsst_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_link_event,
  input logic       out_pass_valid,
  input logic [7:0] out_pass_byte
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_link_event)
      && $stable(out_pass_valid) && $stable(out_pass_byte))
    else $error("stalled result beat changed");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_link_event == lsst_pkg::EV_NONE)
      || (out_link_event == lsst_pkg::EV_CONNECTED)
      || (out_link_event == lsst_pkg::EV_DISCONNECTED))
    else $error("undefined link event code");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pass_valid |-> out_pass_byte == 8'h00)
    else $error("payload byte set on a dropped beat");

  a_event_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_link_event != lsst_pkg::EV_NONE)
      |-> out_pass_valid == (out_link_event == lsst_pkg::EV_DISCONNECTED))
    else $error("link event disagrees with forwarding mode");

endmodule

bind link_status_string_tracker_unit lsst_check u_lsst_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_rx_byte     (in_rx_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_link_event (out_link_event),
  .out_pass_valid (out_pass_valid),
  .out_pass_byte  (out_pass_byte)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for link_status_string_tracker_unit. A queue of received bytes
// holds directed link sessions followed by random sessions, most of them
// well formed and some noisy or broken. A clocked driver sends the bytes,
// and a clocked monitor checks every result beat against a byte-level model
// of the CONNECT, CR LF and DISCONNECT tracker. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_BEATS = 800;

  localparam logic [55:0] CONNECT_STR    = "CONNECT";
  localparam logic [15:0] CRLF_STR       = {8'h0D, 8'h0A};
  localparam logic [79:0] DISCONNECT_STR = "DISCONNECT";

  typedef struct {
    lsst_pkg::byte_t data;
    bit              drain_first;
  } rx_beat_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_link_event;
  logic       out_pass_valid;
  logic [7:0] out_pass_byte;

  rx_beat_t          rx_pending_q[$];
  lsst_pkg::result_t expected_result_q[$];

  lsst_pkg::mode_t   link_mode = lsst_pkg::MODE_CONNECT;
  int                match_pos = 0;
  int                send_gap = 0;
  int                recv_hold = 0;
  bit                send_quiet = 1'b0;
  bit                recv_quiet = 1'b0;
  int                idle_cycles = 0;
  int                fail_count = 0;
  int                bytes_sent = 0;
  int                results_seen = 0;
  int                connect_events = 0;
  int                disconnect_events = 0;
  int                bytes_forwarded = 0;
  lsst_pkg::result_t next_result;

  link_status_string_tracker_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_link_event (out_link_event),
    .out_pass_valid (out_pass_valid),
    .out_pass_byte  (out_pass_byte)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pattern_len(lsst_pkg::mode_t m);
    case (m)
      lsst_pkg::MODE_CRLF: return int'(lsst_pkg::LEN_CRLF);
      lsst_pkg::MODE_DISC: return int'(lsst_pkg::LEN_DISC);
      default:             return int'(lsst_pkg::LEN_CONNECT);
    endcase
  endfunction

  function automatic lsst_pkg::byte_t pattern_char(lsst_pkg::mode_t m, int idx);
    case (m)
      lsst_pkg::MODE_CRLF: return CRLF_STR[8*(1-idx) +: 8];
      lsst_pkg::MODE_DISC: return DISCONNECT_STR[8*(9-idx) +: 8];
      default:             return CONNECT_STR[8*(6-idx) +: 8];
    endcase
  endfunction

  // advance the tracker by one byte and return the result beat it causes
  function automatic lsst_pkg::result_t track_rx_byte(lsst_pkg::byte_t b);
    lsst_pkg::result_t r;
    int                len;
    len = pattern_len(link_mode);
    r.link_event = lsst_pkg::EV_NONE;
    r.pass_valid = (link_mode == lsst_pkg::MODE_DISC);
    r.pass_byte  = r.pass_valid ? b : 8'h00;
    if (match_pos < len && b == pattern_char(link_mode, match_pos)) begin
      match_pos++;
    end else begin
      match_pos = 0;
    end
    if (match_pos >= len) begin
      match_pos = 0;
      case (link_mode)
        lsst_pkg::MODE_CRLF: begin
          link_mode    = lsst_pkg::MODE_DISC;
          r.link_event = lsst_pkg::EV_CONNECTED;
        end
        lsst_pkg::MODE_DISC: begin
          link_mode    = lsst_pkg::MODE_CONNECT;
          r.link_event = lsst_pkg::EV_DISCONNECTED;
        end
        default: link_mode = lsst_pkg::MODE_CRLF;
      endcase
    end
    return r;
  endfunction

  task automatic push_beat(lsst_pkg::byte_t b, bit drain_first);
    rx_beat_t beat;
    beat.data        = b;
    beat.drain_first = drain_first;
    rx_pending_q.push_back(beat);
  endtask

  task automatic push_text(lsst_pkg::mode_t m, int n);
    for (int i = 0; i < n; i++) push_beat(pattern_char(m, i), 1'b0);
  endtask

  // random bytes, half of them drawn from the characters of one text
  task automatic push_noise(lsst_pkg::mode_t m, int n);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) begin
        push_beat(pattern_char(m, $urandom_range(0, pattern_len(m) - 1)), 1'b0);
      end else begin
        push_beat(lsst_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_gap  = 0;
      link_mode = lsst_pkg::MODE_CONNECT;
      match_pos = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_result_q.push_back(track_rx_byte(in_rx_byte));
        bytes_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_pending_q.size() != 0 &&
                     !(rx_pending_q[0].drain_first && expected_result_q.size() != 0)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_pending_q[0].data;
          void'(rx_pending_q.pop_front());
          if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
          send_gap = send_quiet ? 0 : $urandom_range(0, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_result_q.size() == 0) begin
          $error("result beat with no byte outstanding: event %0d pass %0d byte %0h",
                 out_link_event, out_pass_valid, out_pass_byte);
          fail_count++;
        end else begin
          next_result = expected_result_q.pop_front();
          if (out_link_event !== next_result.link_event) begin
            $error("link_event: expected %0d, got %0d", next_result.link_event,
                   out_link_event);
            fail_count++;
          end
          if (out_pass_valid !== next_result.pass_valid) begin
            $error("pass_valid: expected %0d, got %0d", next_result.pass_valid,
                   out_pass_valid);
            fail_count++;
          end
          if (out_pass_byte !== next_result.pass_byte) begin
            $error("pass_byte: expected %02h, got %02h", next_result.pass_byte,
                   out_pass_byte);
            fail_count++;
          end
          if (next_result.link_event == lsst_pkg::EV_CONNECTED) connect_events++;
          if (next_result.link_event == lsst_pkg::EV_DISCONNECTED) disconnect_events++;
          if (next_result.pass_valid) bytes_forwarded++;
        end
        if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
        recv_hold = recv_quiet ? 0 : $urandom_range(0, 18);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int target;

    // byte extremes, naive mismatch on CR CR LF, full session with payload
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_text(lsst_pkg::MODE_CONNECT, 7);
    push_beat(8'h0D, 1'b0);
    push_beat(8'h0D, 1'b0);
    push_beat(8'h0A, 1'b0);
    push_text(lsst_pkg::MODE_CRLF, 2);
    push_beat(8'hFF, 1'b1);
    push_beat(8'h00, 1'b0);
    push_text(lsst_pkg::MODE_DISC, 10);

    target = rx_pending_q.size() + RANDOM_BEATS;
    while (rx_pending_q.size() < target) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat(lsst_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
      end
      push_noise(lsst_pkg::MODE_CONNECT, $urandom_range(0, 4));
      if ($urandom_range(0, 2) == 0) begin
        push_text(lsst_pkg::MODE_CONNECT, $urandom_range(1, 6));
        push_noise(lsst_pkg::MODE_CONNECT, 1);
      end
      if ($urandom_range(0, 7) != 0) push_text(lsst_pkg::MODE_CONNECT, 7);
      push_noise(lsst_pkg::MODE_CRLF, $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        push_text(lsst_pkg::MODE_CRLF, 1);
        push_noise(lsst_pkg::MODE_CONNECT, 1);
      end
      if ($urandom_range(0, 7) != 0) push_text(lsst_pkg::MODE_CRLF, 2);
      push_noise(lsst_pkg::MODE_DISC, $urandom_range(0, 12));
      if ($urandom_range(0, 2) == 0) begin
        push_text(lsst_pkg::MODE_DISC, $urandom_range(1, 9));
        push_noise(lsst_pkg::MODE_DISC, 1);
      end
      if ($urandom_range(0, 7) != 0) push_text(lsst_pkg::MODE_DISC, 10);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Summary: %0d bytes sent, %0d result beats checked, %0d mismatches",
             bytes_sent, results_seen, fail_count);
    $display("Summary: %0d connect and %0d disconnect events, %0d bytes forwarded",
             connect_events, disconnect_events, bytes_forwarded);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lsst_pkg.sv
rtl/core/lsst_match.sv
rtl/core/link_status_string_tracker_unit.sv
rtl/core/lsst_check.sv
tb/sv/tb_top.sv
